@@ design/rotate_pixel_scatter_unit_assert.svh @@
// Assertion macros for the rotate pixel scatter unit.
// RPS_ASSERT is gated by reset, RPS_ASSERT_NR also holds during reset.
`ifndef ROTATE_PIXEL_SCATTER_UNIT_ASSERT_SVH
`define ROTATE_PIXEL_SCATTER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define RPS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define RPS_ASSERT(lbl, prop, msg)
`define RPS_ASSERT_NR(lbl, prop, msg)
`endif
`endif

@@ design/rps_pkg.sv @@
package rps_pkg;

  // Item commands
  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_OUT_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_OUT_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_COS_VALUE  = 3'd2;
  localparam logic [2:0] CFG_SIN_VALUE  = 3'd3;
  localparam logic [2:0] CFG_SHIFT_X    = 3'd4;
  localparam logic [2:0] CFG_SHIFT_Y    = 3'd5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [9:0]         RST_OUT_WIDTH  = 10'd512;
  localparam logic [9:0]         RST_OUT_HEIGHT = 10'd512;
  localparam logic signed [15:0] RST_COS_VALUE  = 16'sd16384;
  localparam logic signed [15:0] RST_SIN_VALUE  = 16'sd0;
  localparam logic [9:0]         RST_SHIFT_X    = 10'd0;
  localparam logic [9:0]         RST_SHIFT_Y    = 10'd0;

  // Level of an unwritten output pixel
  localparam logic [7:0] WHITE_LEVEL = 8'd255;

  typedef struct packed {
    logic       cmd;
    logic [8:0] pos_x;
    logic [8:0] pos_y;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } rps_in_t;

  typedef struct packed {
    logic [8:0] dest_x;
    logic [8:0] dest_y;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } rps_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_OFFS,
    ST_CLAMP,
    ST_ADDR,
    ST_MEM,
    ST_DONE
  } rps_state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic mul_en;
    logic sum_en;
    logic offs_en;
    logic clamp_en;
    logic addr_en;
    logic mem_en;
    logic out_load;
  } rps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } rps_sts_t;

endpackage

@@ design/rps_ctrl.sv @@
module rps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  rps_pkg::rps_sts_t sts_i,
  output rps_pkg::rps_cmd_t cmd_o,
  output logic             in_stall_o
);

  rps_pkg::rps_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rps_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rps_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) state_d = rps_pkg::ST_IDLE;
      end
      rps_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rps_pkg::ST_MUL;
      end
      rps_pkg::ST_MUL:   state_d = rps_pkg::ST_SUM;
      rps_pkg::ST_SUM:   state_d = rps_pkg::ST_OFFS;
      rps_pkg::ST_OFFS:  state_d = rps_pkg::ST_CLAMP;
      rps_pkg::ST_CLAMP: state_d = rps_pkg::ST_ADDR;
      rps_pkg::ST_ADDR:  state_d = rps_pkg::ST_MEM;
      rps_pkg::ST_MEM:   state_d = rps_pkg::ST_DONE;
      rps_pkg::ST_DONE: begin
        if (sts_i.out_free) state_d = rps_pkg::ST_IDLE;
      end
      default: state_d = rps_pkg::ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      rps_pkg::ST_CLEAR: cmd_o.clr_step = 1'b1;
      rps_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      rps_pkg::ST_MUL:   cmd_o.mul_en   = 1'b1;
      rps_pkg::ST_SUM:   cmd_o.sum_en   = 1'b1;
      rps_pkg::ST_OFFS:  cmd_o.offs_en  = 1'b1;
      rps_pkg::ST_CLAMP: cmd_o.clamp_en = 1'b1;
      rps_pkg::ST_ADDR:  cmd_o.addr_en  = 1'b1;
      rps_pkg::ST_MEM:   cmd_o.mem_en   = 1'b1;
      rps_pkg::ST_DONE:  cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ design/rps_datapath.sv @@
module rps_datapath #(
  parameter int unsigned MAX_SIDE  = 512,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [rps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rps_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  rps_pkg::rps_in_t                  in_item_i,
  input  rps_pkg::rps_cmd_t                 cmd_i,
  output rps_pkg::rps_sts_t                 sts_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output rps_pkg::rps_out_t                 out_item_o
);

  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PRW   = 26;                 // 10b signed x 16b signed
  localparam int unsigned SUMW  = PRW + 1;
  localparam int unsigned QW    = SUMW - FRAC_BITS;
  localparam int unsigned VW    = ((QW > 11) ? QW : 11) + 1;
  localparam int unsigned BIAS  = (1 << FRAC_BITS) - 1;

  // Configuration registers
  logic [9:0]         out_width_q, out_height_q, shift_x_q, shift_y_q;
  logic signed [15:0] cos_q, sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q  <= rps_pkg::RST_OUT_WIDTH;
      out_height_q <= rps_pkg::RST_OUT_HEIGHT;
      cos_q        <= rps_pkg::RST_COS_VALUE;
      sin_q        <= rps_pkg::RST_SIN_VALUE;
      shift_x_q    <= rps_pkg::RST_SHIFT_X;
      shift_y_q    <= rps_pkg::RST_SHIFT_Y;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rps_pkg::CFG_OUT_WIDTH:  out_width_q  <= cfg_data_i[9:0];
        rps_pkg::CFG_OUT_HEIGHT: out_height_q <= cfg_data_i[9:0];
        rps_pkg::CFG_COS_VALUE:  cos_q        <= cfg_data_i;
        rps_pkg::CFG_SIN_VALUE:  sin_q        <= cfg_data_i;
        rps_pkg::CFG_SHIFT_X:    shift_x_q    <= cfg_data_i[9:0];
        rps_pkg::CFG_SHIFT_Y:    shift_y_q    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Drop fraction bits with truncation toward zero, then add the offset
  function automatic logic signed [VW-1:0] drop_frac(logic signed [SUMW-1:0] s,
                                                     logic [9:0] sh);
    logic signed [SUMW-1:0] biased;
    logic signed [SUMW-1:0] shifted;
    biased  = s[SUMW-1] ? SUMW'(s + SUMW'(BIAS)) : s;
    shifted = biased >>> FRAC_BITS;
    return VW'($signed(shifted[QW-1:0])) + VW'($signed({1'b0, sh}));
  endfunction

  // Frame size: zero acts as one, oversize acts as MAX_SIDE
  function automatic logic [9:0] eff_size(logic [9:0] r);
    if (r == 10'd0) return 10'd1;
    else if (32'(r) > MAX_SIDE) return 10'(MAX_SIDE);
    else return r;
  endfunction

  function automatic logic [9:0] clamp(logic signed [VW-1:0] v, logic [9:0] size);
    logic signed [VW-1:0] size_s;
    size_s = VW'($signed({1'b0, size}));
    if (v < 0) return 10'd0;
    else if (v >= size_s) return size - 10'd1;
    else return v[9:0];
  endfunction

  // Captured item
  logic        cmd_q;
  logic [8:0]  px_q, py_q;
  logic [23:0] colour_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q    <= in_item_i.cmd;
      px_q     <= in_item_i.pos_x;
      py_q     <= in_item_i.pos_y;
      colour_q <= {in_item_i.red_in, in_item_i.green_in, in_item_i.blue_in};
    end
  end

  // Products
  logic signed [9:0]     x_s, y_s;
  logic signed [PRW-1:0] xc_q, ys_q, yc_q, xs_q;

  assign x_s = $signed({1'b0, px_q});
  assign y_s = $signed({1'b0, py_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      xc_q <= x_s * cos_q;
      ys_q <= y_s * sin_q;
      yc_q <= y_s * cos_q;
      xs_q <= x_s * sin_q;
    end
  end

  // Rotated sums
  logic signed [SUMW-1:0] sum_x_q, sum_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      sum_x_q <= SUMW'(xc_q) + SUMW'(ys_q);
      sum_y_q <= SUMW'(yc_q) - SUMW'(xs_q);
    end
  end

  // Fixed point to integer plus offset
  logic signed [VW-1:0] v_x_q, v_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.offs_en) begin
      v_x_q <= drop_frac(sum_x_q, shift_x_q);
      v_y_q <= drop_frac(sum_y_q, shift_y_q);
    end
  end

  // Clamp for place, echo for read
  logic [9:0] ox_q, oy_q;
  logic       inrange_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clamp_en) begin
      if (cmd_q == rps_pkg::CMD_PLACE) begin
        ox_q <= clamp(v_x_q, eff_size(out_width_q));
        oy_q <= clamp(v_y_q, eff_size(out_height_q));
      end else begin
        ox_q <= {1'b0, px_q};
        oy_q <= {1'b0, py_q};
      end
      inrange_q <= (32'(px_q) < MAX_SIDE) && (32'(py_q) < MAX_SIDE);
    end
  end

  // Store address, row major
  logic [AW-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_en) begin
      addr_q <= AW'(oy_q) * AW'(MAX_SIDE) + AW'(ox_q);
    end
  end

  // Clear sweep counter for the written flags
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == AW'(DEPTH - 1));

  // Frame store and written flags
  logic [23:0]   frame_mem [DEPTH];
  logic          flag_mem  [DEPTH];
  logic [23:0]   frame_rd_q;
  logic          flag_rd_q;
  logic          place_we, read_re, flag_we;
  logic [AW-1:0] flag_addr;

  assign place_we  = cmd_i.mem_en && (cmd_q == rps_pkg::CMD_PLACE);
  assign read_re   = cmd_i.mem_en && (cmd_q == rps_pkg::CMD_READ);
  assign flag_we   = place_we || cmd_i.clr_step;
  assign flag_addr = cmd_i.clr_step ? clr_cnt_q : addr_q;

  always_ff @(posedge clk_i) begin
    if (place_we) frame_mem[addr_q] <= colour_q;
    if (read_re)  frame_rd_q <= frame_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) flag_mem[flag_addr] <= !cmd_i.clr_step;
    if (read_re) flag_rd_q <= flag_mem[addr_q];
  end

  // Output register
  logic              out_valid_q;
  rps_pkg::rps_out_t out_q, out_d;
  logic [23:0]       res_colour;

  always_comb begin
    if (cmd_q == rps_pkg::CMD_PLACE) begin
      res_colour = colour_q;
    end else if (inrange_q && flag_rd_q) begin
      res_colour = frame_rd_q;
    end else begin
      res_colour = {rps_pkg::WHITE_LEVEL, rps_pkg::WHITE_LEVEL, rps_pkg::WHITE_LEVEL};
    end
    out_d.dest_x    = ox_q[8:0];
    out_d.dest_y    = oy_q[8:0];
    out_d.blue_out  = res_colour[7:0];
    out_d.green_out = res_colour[15:8];
    out_d.red_out   = res_colour[23:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= out_d;
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_q;

endmodule

@@ design/rotate_pixel_scatter_unit.sv @@
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o   rps_in_t  (place or read item)
// out      output     out_valid_o/out_stall_i rps_out_t (destination and colour)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item passes from acceptance through the MUL, SUM, OFFS, CLAMP, ADDR, MEM and
// DONE states to the output register; the controller steps it through multiply,
// sum, offset, clamp, address and memory stages one item at a time, and takes a
// new item only after DONE. After reset the written flags are cleared one entry
// a cycle, MAX_SIDE*MAX_SIDE entries (262144 at default), with in_stall_o high;
// config writes are taken. The output register frees the input side: a stalled
// result holds only the next item in its last stage until the register empties.
`include "rotate_pixel_scatter_unit_assert.svh"

module rotate_pixel_scatter_unit #(
  parameter int unsigned MAX_SIDE  = 512,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rps_pkg::rps_in_t               in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rps_pkg::rps_out_t              out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rps_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  rps_pkg::rps_cmd_t cmd;
  rps_pkg::rps_sts_t sts;

  // Config registers are always writable
  assign cfg_ready_o = 1'b1;

  rps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  rps_datapath #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // Checks
  `RPS_ASSERT(a_accept_starts_mul, (in_valid_i && !in_stall_o) |=> cmd.mul_en, "missing multiply")
  `RPS_ASSERT(a_one_stage_busy, $onehot0(cmd), "more than one stage active")
  `RPS_ASSERT(a_load_when_free, cmd.out_load |-> sts.out_free, "result overwritten")
  `RPS_ASSERT_NR(a_no_accept_in_clear, cmd.clr_step |-> in_stall_o, "input open in clear")

endmodule

@@ dv/rotate_pixel_scatter_unit_tb.sv @@
module rotate_pixel_scatter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIDE       = 512;
  localparam longint      Q_ONE      = 64'sd16384;
  localparam int unsigned RAND_ITEMS = 640;
  localparam int unsigned SEGMENTS   = 3;
  localparam logic [23:0] WHITE_RGB  = {rps_pkg::WHITE_LEVEL, rps_pkg::WHITE_LEVEL,
                                        rps_pkg::WHITE_LEVEL};

  // Register indexes with no register behind them
  localparam logic [2:0] CFG_UNMAPPED_A = 3'd6;
  localparam logic [2:0] CFG_UNMAPPED_B = 3'd7;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  rps_pkg::rps_in_t               in_item_i;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  rps_pkg::rps_out_t              out_item_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [rps_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [rps_pkg::CFG_DATA_W-1:0] cfg_data_i;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned err_cnt        = 0;

  // Shadow copy of the geometry registers and the output frame
  logic [9:0]         width_q  = rps_pkg::RST_OUT_WIDTH;
  logic [9:0]         height_q = rps_pkg::RST_OUT_HEIGHT;
  logic signed [15:0] cos_q    = rps_pkg::RST_COS_VALUE;
  logic signed [15:0] sin_q    = rps_pkg::RST_SIN_VALUE;
  logic [9:0]         shx_q    = rps_pkg::RST_SHIFT_X;
  logic [9:0]         shy_q    = rps_pkg::RST_SHIFT_Y;
  logic [23:0]        frame_rgb [int unsigned];
  int unsigned        placed_addr_q[$];
  rps_pkg::rps_out_t  pending_pixels_q[$];

  rotate_pixel_scatter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #15ms;
    $display("rotate_pixel_scatter_unit test failed");
    $finish;
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  // Drop fraction bits, add offset, clamp into [0, size-1]
  function automatic logic [8:0] map_axis(longint prod, logic [9:0] shift,
                                          logic [9:0] size_reg);
    longint v;
    longint sh;
    longint lim;
    sh = shift;
    if (size_reg == '0) begin
      lim = 1;
    end else if (size_reg > SIDE) begin
      lim = SIDE;
    end else begin
      lim = size_reg;
    end
    v = prod / Q_ONE + sh;
    if (v < 0) v = 0;
    if (v >= lim) v = lim - 1;
    return v[8:0];
  endfunction

  // Rotate a placed pixel into the frame, or look up a read pixel
  function automatic rps_pkg::rps_out_t rotate_and_store(rps_pkg::rps_in_t it);
    rps_pkg::rps_out_t res;
    longint            x;
    longint            y;
    longint            c;
    longint            s;
    int unsigned       addr;
    x = it.pos_x;
    y = it.pos_y;
    c = cos_q;
    s = sin_q;
    if (it.cmd == rps_pkg::CMD_PLACE) begin
      res.dest_x    = map_axis(x * c + y * s, shx_q, width_q);
      res.dest_y    = map_axis(y * c - x * s, shy_q, height_q);
      res.blue_out  = it.blue_in;
      res.green_out = it.green_in;
      res.red_out   = it.red_in;
      addr = res.dest_y * SIDE + res.dest_x;
      frame_rgb[addr] = {it.red_in, it.green_in, it.blue_in};
      placed_addr_q.push_back(addr);
    end else begin
      res.dest_x = it.pos_x;
      res.dest_y = it.pos_y;
      addr = it.pos_y * SIDE + it.pos_x;
      {res.red_out, res.green_out, res.blue_out} =
        frame_rgb.exists(addr) ? frame_rgb[addr] : WHITE_RGB;
    end
    return res;
  endfunction

  function automatic void apply_reg(logic [rps_pkg::CFG_IDX_W-1:0] idx,
                                    logic [rps_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      rps_pkg::CFG_OUT_WIDTH:  width_q  = data[9:0];
      rps_pkg::CFG_OUT_HEIGHT: height_q = data[9:0];
      rps_pkg::CFG_COS_VALUE:  cos_q    = data;
      rps_pkg::CFG_SIN_VALUE:  sin_q    = data;
      rps_pkg::CFG_SHIFT_X:    shx_q    = data[9:0];
      rps_pkg::CFG_SHIFT_Y:    shy_q    = data[9:0];
      default: ;
    endcase
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // Track register writes and accepted items, check every accepted result
  always @(posedge clk_i) begin : result_check
    rps_pkg::rps_out_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) pending_pixels_q.push_back(rotate_and_store(in_item_i));
      if (out_valid_o && !out_stall_i) begin
        if (pending_pixels_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %p", $time, out_item_o);
          err_cnt++;
        end else begin
          want = pending_pixels_q.pop_front();
          cmp_field("dest_x", want.dest_x, out_item_o.dest_x);
          cmp_field("dest_y", want.dest_y, out_item_o.dest_y);
          cmp_field("blue_out", want.blue_out, out_item_o.blue_out);
          cmp_field("green_out", want.green_out, out_item_o.green_out);
          cmp_field("red_out", want.red_out, out_item_o.red_out);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back items need no extra toggle.
  task automatic send_item(input rps_pkg::rps_in_t item);
    logic [63:0] noise;
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      do begin
        noise     = {$urandom, $urandom};
        in_item_i = noise[$bits(rps_pkg::rps_in_t)-1:0];
        @(negedge clk_i);
      end while ($urandom_range(99) < src_idle_pct);
    end
    in_item_i  = item;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_pixels_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [rps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rps_pkg::CFG_DATA_W-1:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    @(negedge clk_i);
  endtask

  task automatic place_px(input int unsigned x, input int unsigned y, input logic [23:0] rgb);
    rps_pkg::rps_in_t it;
    it.cmd   = rps_pkg::CMD_PLACE;
    it.pos_x = 9'(x);
    it.pos_y = 9'(y);
    {it.red_in, it.green_in, it.blue_in} = rgb;
    send_item(it);
  endtask

  // Colour fields of a read carry junk; the block must ignore them
  task automatic read_px(input int unsigned x, input int unsigned y);
    rps_pkg::rps_in_t it;
    it.cmd   = rps_pkg::CMD_READ;
    it.pos_x = 9'(x);
    it.pos_y = 9'(y);
    {it.red_in, it.green_in, it.blue_in} = 24'($urandom);
    send_item(it);
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd512;
      3: return 16'($urandom_range(1023, 513));
      4, 5, 6: return 16'($urandom_range(511, 2));
      default: return 16'($urandom_range(512, 400));
    endcase
  endfunction

  function automatic logic [15:0] pick_shift();
    if ($urandom_range(3) == 0) return 16'(512 * $urandom_range(1));
    return 16'($urandom_range(512));
  endfunction

  task automatic random_geometry();
    int c;
    int s;
    case ($urandom_range(5))
      0: begin c = 16384;  s = 0;      end
      1: begin c = -16384; s = 0;      end
      2: begin c = 0;      s = 16384;  end
      3: begin c = 0;      s = -16384; end
      default: begin
        c = int'($urandom_range(32768)) - 16384;
        s = int'($urandom_range(32768)) - 16384;
      end
    endcase
    write_reg(rps_pkg::CFG_OUT_WIDTH, pick_size());
    write_reg(rps_pkg::CFG_OUT_HEIGHT, pick_size());
    write_reg(rps_pkg::CFG_COS_VALUE, 16'(c));
    write_reg(rps_pkg::CFG_SIN_VALUE, 16'(s));
    write_reg(rps_pkg::CFG_SHIFT_X, pick_shift());
    write_reg(rps_pkg::CFG_SHIFT_Y, pick_shift());
  endtask

  // Reads mostly land on pixels already placed so stored colours come back
  function automatic rps_pkg::rps_in_t random_item();
    rps_pkg::rps_in_t it;
    logic [63:0]      bits;
    int unsigned      addr;
    bits = {$urandom, $urandom};
    it   = bits[$bits(rps_pkg::rps_in_t)-1:0];
    if ($urandom_range(99) < 55) begin
      it.cmd = rps_pkg::CMD_PLACE;
    end else begin
      it.cmd = rps_pkg::CMD_READ;
      if (placed_addr_q.size() != 0 && $urandom_range(99) < 60) begin
        addr     = placed_addr_q[$urandom_range(placed_addr_q.size() - 1)];
        it.pos_x = 9'(addr % SIDE);
        it.pos_y = 9'(addr / SIDE);
      end
    end
    return it;
  endfunction

  // Reset geometry maps every pixel onto itself; unwritten reads give white
  task automatic test_identity_map();
    read_px(0, 0);
    place_px(0, 0, 24'h000000);
    place_px(511, 511, 24'hffffff);
    place_px(511, 0, 24'h3c5aa5);
    read_px(0, 0);
    read_px(511, 0);
    read_px(256, 255);
    drain();
  endtask

  task automatic test_clamp_cases();
    // 180 degrees: both coordinates go negative and clamp to zero
    write_reg(rps_pkg::CFG_COS_VALUE, 16'(-16384));
    place_px(5, 7, 24'h102030);
    drain();
    // full offset pushes past the frame edge
    write_reg(rps_pkg::CFG_COS_VALUE, 16'd16384);
    write_reg(rps_pkg::CFG_SHIFT_X, 16'd512);
    write_reg(rps_pkg::CFG_SHIFT_Y, 16'd512);
    place_px(3, 4, 24'h445566);
    drain();
    // zero-sized frame behaves as one pixel
    write_reg(rps_pkg::CFG_OUT_WIDTH, 16'd0);
    write_reg(rps_pkg::CFG_OUT_HEIGHT, 16'd0);
    write_reg(rps_pkg::CFG_SHIFT_X, 16'd0);
    write_reg(rps_pkg::CFG_SHIFT_Y, 16'd0);
    place_px(100, 200, 24'h778899);
    drain();
    // oversized width and height limit to the store side
    write_reg(rps_pkg::CFG_OUT_WIDTH, 16'd1023);
    write_reg(rps_pkg::CFG_OUT_HEIGHT, 16'd600);
    write_reg(rps_pkg::CFG_SIN_VALUE, 16'd16384);
    place_px(300, 400, 24'haabbcc);
    place_px(400, 100, 24'hddeeff);
    drain();
    // 45 degrees: negative fractions truncate toward zero before the offset
    write_reg(rps_pkg::CFG_OUT_WIDTH, 16'd512);
    write_reg(rps_pkg::CFG_OUT_HEIGHT, 16'd512);
    write_reg(rps_pkg::CFG_COS_VALUE, 16'd11585);
    write_reg(rps_pkg::CFG_SIN_VALUE, 16'd11585);
    write_reg(rps_pkg::CFG_SHIFT_Y, 16'd10);
    place_px(1, 0, 24'h0f1e2d);
    place_px(3, 1, 24'h3c4b5a);
    drain();
    // writes to unmapped indexes leave the geometry alone
    write_reg(CFG_UNMAPPED_A, 16'h0001);
    write_reg(CFG_UNMAPPED_B, 16'hffff);
    place_px(2, 2, 24'h696969);
    drain();
  endtask

  // Shrinking the frame keeps what was stored outside it
  task automatic test_frame_resize();
    write_reg(rps_pkg::CFG_OUT_WIDTH, 16'd16);
    write_reg(rps_pkg::CFG_OUT_HEIGHT, 16'd16);
    write_reg(rps_pkg::CFG_COS_VALUE, 16'd16384);
    write_reg(rps_pkg::CFG_SIN_VALUE, 16'd0);
    write_reg(rps_pkg::CFG_SHIFT_X, 16'd0);
    write_reg(rps_pkg::CFG_SHIFT_Y, 16'd0);
    read_px(511, 511);
    read_px(300, 300);
    place_px(20, 20, 24'h5a5a5a);
    read_px(15, 15);
    drain();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin src_idle_pct = 34; sink_stall_pct = 34; end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        random_geometry();
        repeat (RAND_ITEMS / (4 * SEGMENTS)) send_item(random_item());
        drain();
      end
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_identity_map();
    test_clamp_cases();
    test_frame_resize();
    test_random_traffic();

    repeat (16) @(posedge clk_i);
    if (err_cnt == 0 && pending_pixels_q.size() == 0) begin
      $display("rotate_pixel_scatter_unit test passed");
    end else begin
      $display("rotate_pixel_scatter_unit test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/rps_pkg.sv
design/rps_ctrl.sv
design/rps_datapath.sv
design/rotate_pixel_scatter_unit.sv
dv/rotate_pixel_scatter_unit_tb.sv
